>>> rtl/core/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants of the radix printer
// Command format passed from the front end to the digit engine, ASCII codes
// and the reciprocal used for divide-by-ten.
// ----------------------------------------------------------------------------
package frp_pkg;

  // Argument field width on the input channel
  localparam int ARG_W = 32;

  // ASCII codes
  localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
  localparam logic [7:0] CH_LU   = 8'h75;  // 'u'
  localparam logic [7:0] CH_LO   = 8'h6F;  // 'o'
  localparam logic [7:0] CH_LX   = 8'h78;  // 'x'
  localparam logic [7:0] CH_UX   = 8'h58;  // 'X'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_UA   = 8'h41;  // 'A'
  localparam logic [7:0] CH_LA   = 8'h61;  // 'a'

  // q = (v * RECIP10) >> RECIP_SHIFT equals v / 10 for any 32-bit v
  localparam logic [ARG_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;
  localparam logic [3:0]       DEC_LIMIT   = 4'd10;

  // Command kinds
  typedef enum logic [1:0] {
    OP_LIT = 2'd0,
    OP_DEC = 2'd1,
    OP_OCT = 2'd2,
    OP_HEX = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             upper;
    logic [7:0]       ch;
    logic [ARG_W-1:0] arg;
  } cmd_t;

  // Digit value to ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < DEC_LIMIT) begin
      base = CH_ZERO + {4'b0000, d};
    end else begin
      base = (upper ? CH_UA : CH_LA) + {4'b0000, d} - {4'b0000, DEC_LIMIT};
    end
    return base;
  endfunction

endpackage

>>> rtl/core/frp_if.sv
// ----------------------------------------------------------------------------
// frp_if: valid/ready channels of the radix printer
// frp_fmt_if carries format bytes with their argument, frp_text_if carries
// emitted characters with the end-of-run mark.
// ----------------------------------------------------------------------------
interface frp_fmt_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               fmt_char;
  logic [frp_pkg::ARG_W-1:0] arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface frp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

>>> rtl/core/frp_front.sv
// ----------------------------------------------------------------------------
// frp_front: format byte classifier
// Tracks the pending '%' and turns each accepted byte, but a '%' that arms it,
// into a literal or a conversion command for the command queue.
// ----------------------------------------------------------------------------
module frp_front (
  input  logic          clk,
  input  logic          rst,
  frp_fmt_if.sink       fmt,
  input  logic          full,
  output logic          push,
  output frp_pkg::cmd_t cmd
);
  import frp_pkg::*;

  logic pending;
  logic accept;

  assign fmt.ready = !full;
  assign accept    = fmt.valid && fmt.ready;

  // A '%' that arms the flag produces no command
  assign push = accept && (pending || (fmt.fmt_char != CH_PCT));

  // Decode the selector byte
  always_comb begin
    cmd.ch    = fmt.fmt_char;
    cmd.arg   = fmt.arg_value;
    cmd.upper = (fmt.fmt_char == CH_UX);
    cmd.op    = OP_LIT;
    if (pending) begin
      unique case (fmt.fmt_char) inside
        CH_LU:        cmd.op = OP_DEC;
        CH_LO:        cmd.op = OP_OCT;
        CH_LX, CH_UX: cmd.op = OP_HEX;
        default:      cmd.op = OP_LIT;
      endcase
    end
  end

  // Pending '%' flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      if (pending) begin
        pending <= 1'b0;
      end else if (fmt.fmt_char == CH_PCT) begin
        pending <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/frp_queue.sv
// ----------------------------------------------------------------------------
// frp_queue: two-entry command queue
// Decouples the classifier from the digit engine.
// ----------------------------------------------------------------------------
module frp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frp_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  output frp_pkg::cmd_t q_cmd,
  input  logic          pop
);
  import frp_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = slot[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/frp_back.sv
// ----------------------------------------------------------------------------
// frp_back: digit engine and output register
// Splits a conversion value into digits least significant first (shift for
// octal/hex, reciprocal multiply for decimal), then plays them out in reverse.
// ----------------------------------------------------------------------------
module frp_back #(
  parameter int EFF_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  frp_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          busy,
  frp_text_if.source    text
);
  import frp_pkg::*;

  localparam int DIGIT_SLOTS = (EFF_BITS + 2) / 3;
  localparam int CW          = $clog2(DIGIT_SLOTS + 1);
  localparam int IW          = $clog2(DIGIT_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SPLIT = 4'b0010,
    ST_REM   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t              state;
  op_t                 op;
  logic                upper;
  logic [EFF_BITS-1:0] val;
  logic [2*ARG_W-1:0]  prod;
  logic [3:0]          dig [DIGIT_SLOTS];
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       rd_cnt;
  logic                o_valid;
  logic [7:0]          o_char;
  logic                o_last;

  logic                out_free;
  logic                o_load;
  logic [EFF_BITS-1:0] q_dec;
  logic [3:0]          q10_lo;
  logic [3:0]          rem_dig;
  logic [3:0]          split_dig;
  logic [EFF_BITS-1:0] split_val;
  logic [2*ARG_W-1:0]  mul_a;
  logic [2*ARG_W-1:0]  mul_b;

  assign text.valid    = o_valid;
  assign text.out_char = o_char;
  assign text.run_last = o_last;

  assign out_free = !o_valid || text.ready;
  assign busy     = (state != ST_IDLE);
  assign rd_cnt   = cnt - CW'(1);

  // Pop a literal only when it can go straight to the output register
  assign q_pop = (state == ST_IDLE) && q_valid && ((q_cmd.op != OP_LIT) || out_free);

  // Output register takes a popped literal or the next digit
  assign o_load = out_free && (((state == ST_IDLE) && q_valid && (q_cmd.op == OP_LIT)) ||
                               (state == ST_EMIT));

  // Octal and hex digits by shifting
  assign split_dig = (op == OP_HEX) ? val[3:0] : {1'b0, val[2:0]};
  assign split_val = (op == OP_HEX) ? (val >> 4) : (val >> 3);

  // Decimal: quotient from the registered product, remainder from low bits only
  assign mul_a   = {{ARG_W{1'b0}}, ARG_W'(val)};
  assign mul_b   = {{ARG_W{1'b0}}, RECIP10};
  assign q_dec   = EFF_BITS'(prod[2*ARG_W-1:RECIP_SHIFT]);
  assign q10_lo  = {q_dec[0], 3'b000} + {q_dec[2:0], 1'b0};
  assign rem_dig = val[3:0] - q10_lo;

  // Digit buffer and operands
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op    <= q_cmd.op;
        upper <= q_cmd.upper;
        val   <= q_cmd.arg[EFF_BITS-1:0];
      end
      ST_SPLIT: begin
        if (op == OP_DEC) begin
          prod <= mul_a * mul_b;
        end else begin
          dig[cnt[IW-1:0]] <= split_dig;
          val              <= split_val;
        end
      end
      ST_REM: begin
        dig[cnt[IW-1:0]] <= rem_dig;
        val              <= q_dec;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (o_valid && text.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.op == OP_LIT) begin
              if (out_free) begin
                o_char  <= q_cmd.ch;
                o_last  <= 1'b1;
              end
            end else begin
              cnt   <= '0;
              state <= ST_SPLIT;
            end
          end
        end
        ST_SPLIT: begin
          if (op == OP_DEC) begin
            state <= ST_REM;
          end else begin
            cnt <= cnt + CW'(1);
            if (split_val == '0) state <= ST_EMIT;
          end
        end
        ST_REM: begin
          cnt <= cnt + CW'(1);
          state <= (q_dec == '0) ? ST_EMIT : ST_SPLIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            o_char  <= digit_char(dig[rd_cnt[IW-1:0]], upper);
            o_last  <= (cnt == CW'(1));
            cnt     <= rd_cnt;
            if (cnt == CW'(1)) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/format_radix_printer_unit.sv
// Path: a byte reaches the command queue at acceptance and a literal then goes
// to the output register; hex/octal is split one digit per split step, decimal
// with a multiply step and a remainder step per digit.
// Throughput: one literal per cycle while the output is not stalled; the digit
// engine takes no new command until all n digits (n up to 11) of a conversion are out.
// Reset: synchronous; clears the pending '%', the queue and the output beat.
// ----------------------------------------------------------------------------
// format_radix_printer_unit: printf-style unsigned formatter
// Echoes format bytes and expands %u, %o, %x and %X into digit runs.
// ----------------------------------------------------------------------------
module format_radix_printer_unit #(
  parameter int ARG_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  frp_fmt_if.sink    fmt,
  frp_text_if.source text
);
  import frp_pkg::*;

  localparam int EFF_BITS = (ARG_BITS < ARG_W) ? ARG_BITS : ARG_W;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic busy;

  frp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .fmt  (fmt),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  frp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  frp_back #(
    .EFF_BITS (EFF_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .busy    (busy),
    .text    (text)
  );

`ifndef SYNTH
  // Engine never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // Engine takes a new command only when idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> !busy)
    else $error("command popped while conversion in progress");

  // A conversion starts only from a popped command
  a_busy_start: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(q_pop))
    else $error("digit engine started without a command");
`endif

endmodule

>>> tb/frp_text_checker.sv
// ----------------------------------------------------------------------------
// frp_text_checker: output checker of the radix printer
// Watches both channels, predicts the text beats of every accepted format
// byte and compares each accepted text beat against the oldest prediction.
// ----------------------------------------------------------------------------
module frp_text_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fmt_valid,
  input  logic                     fmt_ready,
  input  logic [7:0]               fmt_char,
  input  logic [frp_pkg::ARG_W-1:0] arg_value,
  input  logic                     text_valid,
  input  logic                     text_ready,
  input  logic [7:0]               out_char,
  input  logic                     run_last,
  output int                       fail_count,
  output int                       beats_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import frp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  text_beat_t due_q[$];
  logic       pct_armed;
  int         miss_n = 0;

  assign fail_count = miss_n;

  // Digits of v in the given radix, most significant first, last one marked
  function automatic void queue_digits(logic [ARG_W-1:0] v, int unsigned radix,
                                       logic upper);
    logic [7:0] dig [12];
    logic [3:0] d;
    int         n;
    n = 0;
    do begin
      d = 4'(v % radix);
      if (d < 4'd10) dig[n] = CH_ZERO + {4'b0000, d};
      else           dig[n] = (upper ? CH_UA : CH_LA) + {4'b0000, d} - 8'd10;
      n++;
      v = v / radix;
    end while (v != '0);
    for (int k = n - 1; k >= 0; k--) begin
      due_q.push_back('{ch: dig[k], last: (k == 0)});
    end
  endfunction

  // Expected text beats of one format byte
  function automatic void predict_text(logic [7:0] c, logic [ARG_W-1:0] a);
    if (!pct_armed) begin
      if (c == CH_PCT) pct_armed = 1'b1;
      else             due_q.push_back('{ch: c, last: 1'b1});
    end else begin
      pct_armed = 1'b0;
      case (c)
        CH_LU:   queue_digits(a, 10, 1'b0);
        CH_LO:   queue_digits(a, 8, 1'b0);
        CH_LX:   queue_digits(a, 16, 1'b0);
        CH_UX:   queue_digits(a, 16, 1'b1);
        default: due_q.push_back('{ch: c, last: 1'b1});
      endcase
    end
  endfunction

  // Compare text beats first; a beat never stems from a byte taken the same edge
  always @(posedge clk) begin : watch
    text_beat_t want;
    if (rst) begin
      pct_armed = 1'b0;
      due_q.delete();
      beats_due <= 0;
    end else begin
      if (text_valid && text_ready) begin
        if (due_q.size() == 0) begin
          if (miss_n < 10)
            $display("%0t: unexpected text beat out_char=%h run_last=%b",
                     $realtime, out_char, run_last);
          miss_n++;
        end else begin
          want = due_q.pop_front();
          if (out_char !== want.ch || run_last !== want.last) begin
            if (miss_n < 10)
              $display("%0t: text beat mismatch out_char exp %h got %h, run_last exp %b got %b",
                       $realtime, want.ch, out_char, want.last, run_last);
            miss_n++;
          end
        end
      end
      if (fmt_valid && fmt_ready) predict_text(fmt_char, arg_value);
      beats_due <= due_q.size();
    end
  end

endmodule

>>> tb/tb_format_radix_printer_unit.sv
// ----------------------------------------------------------------------------
// tb_format_radix_printer_unit: testbench of the radix printer
// Drives directed and random format bytes with random gaps and output
// stalls, including a long output hold-off and a full drain; the checker
// predicts every text beat and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_format_radix_printer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import frp_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;
  localparam int RAND_ITEMS  = 77;

  logic clk;
  logic rst;
  int   fail_count;
  int   beats_due;
  int   sent_n;
  int   taken_n;
  int   idle_cycles;
  bit   fmt_rush;
  bit   text_rush;
  bit   hold_req;
  bit   hold_done;

  frp_fmt_if  fmt_ch ();
  frp_text_if text_ch ();

  format_radix_printer_unit uut (
    .clk  (clk),
    .rst  (rst),
    .fmt  (fmt_ch),
    .text (text_ch)
  );

  frp_text_checker chk (
    .clk        (clk),
    .rst        (rst),
    .fmt_valid  (fmt_ch.valid),
    .fmt_ready  (fmt_ch.ready),
    .fmt_char   (fmt_ch.fmt_char),
    .arg_value  (fmt_ch.arg_value),
    .text_valid (text_ch.valid),
    .text_ready (text_ch.ready),
    .out_char   (text_ch.out_char),
    .run_last   (text_ch.run_last),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One format beat after a random gap; returns at the accepting edge
  task automatic send_beat(input logic [7:0] c, input logic [ARG_W-1:0] a);
    int gap;
    if (sent_n % 16 == 0) fmt_rush = ($urandom_range(0, 2) == 0);
    gap = fmt_rush ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      fmt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fmt_ch.valid     <= 1'b1;
    fmt_ch.fmt_char  <= c;
    fmt_ch.arg_value <= a;
    @(posedge clk);
    while (!fmt_ch.ready) @(posedge clk);
    sent_n++;
  endtask

  // Stop offering and wait until every predicted beat has been taken
  task automatic drain_text();
    fmt_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int               pick;
    logic [7:0]       sel;
    logic [ARG_W-1:0] arg;
    rst                = 1'b1;
    sent_n             = 0;
    fmt_rush           = 1'b0;
    hold_req           = 1'b0;
    hold_done          = 1'b0;
    fmt_ch.valid      <= 1'b0;
    fmt_ch.fmt_char   <= 8'h00;
    fmt_ch.arg_value  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: literals, decimal and octal at their extremes, both hex cases, special selectors
    send_beat("A", $urandom);
    send_beat(CH_PCT, $urandom);
    send_beat(CH_LU, '0);
    send_beat(CH_PCT, $urandom);
    send_beat(CH_LU, '1);
    send_beat(CH_PCT, $urandom);
    send_beat(CH_LO, '1);
    send_beat(CH_PCT, $urandom);
    send_beat(CH_LO, '0);
    send_beat(CH_PCT, $urandom);
    send_beat(CH_LX, 32'hDEAD_BEEF);
    send_beat(CH_PCT, $urandom);
    send_beat(CH_UX, 32'hABCD_EF01);
    // percent then percent echoes one percent
    send_beat(CH_PCT, $urandom);
    send_beat(CH_PCT, $urandom);
    // unknown selector is echoed
    send_beat(CH_PCT, $urandom);
    send_beat("q", $urandom);
    // NUL and top byte as plain literals, NUL as a selector
    send_beat(8'h00, '0);
    send_beat(8'hFF, '1);
    send_beat(CH_PCT, $urandom);
    send_beat(8'h00, $urandom);
    // trailing percent waits for its selector across a gap
    send_beat(CH_PCT, $urandom);
    drain_text();
    send_beat(CH_LX, 32'd9);
    drain_text();

    // Random: mostly conversions with varied digit counts, some noise
    while (sent_n < 23 + RAND_ITEMS) begin
      if (sent_n >= 60 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 19);
      arg  = $urandom >> $urandom_range(0, 31);
      if (pick < 12) begin
        case ($urandom_range(0, 3))
          0:       sel = CH_LU;
          1:       sel = CH_LO;
          2:       sel = CH_LX;
          default: sel = CH_UX;
        endcase
        send_beat(CH_PCT, $urandom);
        send_beat(sel, arg);
      end else if (pick < 17) begin
        send_beat(8'($urandom_range(0, 255)), arg);
      end else begin
        send_beat(CH_PCT, $urandom);
        send_beat(8'($urandom_range(0, 255)), arg);
      end
    end

    // End of run
    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("format_radix_printer_unit verification clean");
    end else begin
      $display("format_radix_printer_unit verification failed");
    end
    $finish;
  end

  // Text receiver: random stalls, bursts of none, one long hold-off
  initial begin
    int stall;
    bit held;
    taken_n        = 0;
    text_rush      = 1'b0;
    held           = 1'b0;
    text_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken_n % 20 == 0) text_rush = ($urandom_range(0, 2) == 0);
      if (hold_req && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = text_rush ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        text_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      text_ch.ready <= 1'b1;
      @(posedge clk);
      while (!text_ch.valid) @(posedge clk);
      taken_n++;
    end
  end

  // Watchdog on cycles with no beat taken on either channel
  always @(posedge clk) begin
    if (rst || (fmt_ch.valid && fmt_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("format_radix_printer_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
rtl/core/frp_pkg.sv
rtl/core/frp_if.sv
rtl/core/frp_front.sv
rtl/core/frp_queue.sv
rtl/core/frp_back.sv
rtl/core/format_radix_printer_unit.sv
tb/frp_text_checker.sv
tb/tb_format_radix_printer_unit.sv
